[rtl/core/rtphdr_pkg.sv]
// Shared types and constants for the RTP transmit header generator.
// Holds the transaction structs, the sequencer states and the code values.
// No dependencies.
`default_nettype none

package rtphdr_pkg;

  // Field widths
  localparam int unsigned SecW     = 32;
  localparam int unsigned NsecW    = 30;
  localparam int unsigned UpsW     = 20;
  localparam int unsigned NpuW     = 30;
  localparam int unsigned QuantW   = 16;
  localparam int unsigned TsW      = 32;
  localparam int unsigned SeqW     = 16;
  localparam int unsigned IntvW    = 16;
  localparam int unsigned CntW     = 5;
  localparam int unsigned AddrW    = 5;
  localparam int unsigned DataW    = 32;

  // Last step of each shared-unit pass
  localparam logic [CntW-1:0] MulLast = CntW'(UpsW - 1);
  localparam logic [CntW-1:0] DivLast = CntW'(NsecW - 1);
  localparam logic [CntW-1:0] ModLast = CntW'(TsW - 1);

  // Action codes
  localparam logic [1:0] ACT_SEND    = 2'd0;
  localparam logic [1:0] ACT_SKIP    = 2'd1;
  localparam logic [1:0] ACT_RESTART = 2'd2;

  // Status codes
  localparam logic [1:0] STS_EMIT   = 2'd0;
  localparam logic [1:0] STS_REJECT = 2'd1;
  localparam logic [1:0] STS_OTHER  = 2'd2;

  // Register indexes
  localparam logic [2:0] REG_READY   = 3'd0;
  localparam logic [2:0] REG_UPS     = 3'd1;
  localparam logic [2:0] REG_NPU     = 3'd2;
  localparam logic [2:0] REG_QUANTUM = 3'd3;
  localparam logic [2:0] REG_OFFSET  = 3'd4;
  localparam logic [2:0] REG_SOURCE  = 3'd5;
  localparam logic [2:0] REG_RTCP    = 3'd6;
  localparam logic [2:0] REG_INITSEQ = 3'd7;

  // Register reset values
  localparam logic [UpsW-1:0]   UpsReset     = UpsW'(8000);
  localparam logic [NpuW-1:0]   NpuReset     = NpuW'(125000);
  localparam logic [QuantW-1:0] QuantumReset = QuantW'(160);

  typedef struct packed {
    logic [1:0]        action;
    logic [SecW-1:0]   now_sec;
    logic [NsecW-1:0]  now_nsec;
    logic [15:0]       data_len;
    logic [6:0]        media_type;
    logic              marker_in;
    logic              mark_on_seed;
    logic              rtcp_now;
  } item_t;

  typedef struct packed {
    logic [1:0]      status;
    logic            marker_out;
    logic [6:0]      type_out;
    logic [SeqW-1:0] sequence_out;
    logic [TsW-1:0]  timestamp_out;
    logic [31:0]     source_out;
    logic            rtcp_request;
    logic [TsW-1:0]  rtcp_timestamp;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_MUL,
    ST_DIV,
    ST_ADDQ,
    ST_ADDO,
    ST_SUBD,
    ST_MOD,
    ST_NUDGE,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

[rtl/core/rtp_tx_header_generator.sv]
// RTP transmit header generator: sequence, timestamp and RTCP request logic.
// Depends on rtphdr_pkg; one shared 32-bit adder/subtractor does the timestamp arithmetic.
//
// Skip, restart, rejected and ordinary sends pass from acceptance through the
// decide and finish steps to the result. A first send adds a 20-step multiply
// and, unless nanoseconds per unit is zero, a 30-step divide; a send after restart
// may add a 32-step modulo, all through the single shared adder.
// One item is in work at a time; a finished result waits in the output register.
// Reset (rst, synchronous) returns configuration to defaults and clears state.
`default_nettype none

module rtp_tx_header_generator
  import rtphdr_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  // input channel
  input  wire logic             item_valid,
  output logic                  item_stall,
  input  wire item_t            item,
  // result channel
  output logic                  result_valid,
  input  wire logic             result_stall,
  output result_t               result,
  // configuration port
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic [DataW-1:0]      prdata,
  output logic                  pready
);

  // Configuration registers
  logic              endpoint_ready;
  logic [UpsW-1:0]   units_per_second;
  logic [NpuW-1:0]   nanoseconds_per_unit;
  logic [QuantW-1:0] quantum_units;
  logic [TsW-1:0]    timestamp_offset;
  logic [31:0]       source_id;
  logic [IntvW-1:0]  rtcp_interval;
  logic [SeqW-1:0]   initial_sequence;

  // Protocol state
  logic              started;
  logic              restart_pending;
  logic [SeqW-1:0]   next_sequence;
  logic [TsW-1:0]    next_timestamp;
  logic [IntvW-1:0]  rtcp_counter;
  logic [31:0]       packet_count;
  logic [63:0]       byte_count;

  // Sequencer and working registers
  state_t            state;
  state_t            state_next;
  item_t             item_q;
  logic              reseed;
  logic              back;
  logic [CntW-1:0]   cnt;
  logic [TsW-1:0]    acc;
  logic [TsW-1:0]    mcand;
  logic [UpsW-1:0]   mplier;
  logic [NsecW-1:0]  quo;
  logic [NpuW-1:0]   rem;

  // Shared adder/subtractor
  logic [31:0]       alu_a;
  logic [31:0]       alu_b;
  logic              alu_sub;
  logic [32:0]       alu_sum;

  logic              cfg_write;
  logic              fin_load;
  logic              reseed_go;
  logic              nudge;
  logic [TsW-1:0]    ts_sel;
  logic [IntvW-1:0]  rtcp_cnt_inc;
  logic              rtcp_hit;
  logic              emit;
  result_t           result_next;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  assign alu_sum = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + 33'(alu_sub);

  assign reseed_go = (item_q.action == ACT_SEND) && endpoint_ready &&
                     (!started || restart_pending);
  assign fin_load  = (state == ST_FINISH) && (!result_valid || !result_stall);
  assign nudge     = back || ((quantum_units != '0) && (rem == '0));
  assign ts_sel    = reseed ? acc : next_timestamp;
  assign emit      = (item_q.action == ACT_SEND) && endpoint_ready;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (item_valid) state_next = ST_DECIDE;
      ST_DECIDE: state_next = reseed_go ? ST_MUL : ST_FINISH;
      ST_MUL: begin
        if (cnt == MulLast) state_next = (nanoseconds_per_unit == '0) ? ST_ADDQ : ST_DIV;
      end
      ST_DIV:    if (cnt == DivLast) state_next = ST_ADDQ;
      ST_ADDQ:   state_next = ST_ADDO;
      ST_ADDO:   state_next = started ? ST_SUBD : ST_FINISH;
      ST_SUBD: begin
        if ((alu_sum[31:0] == '0) || alu_sum[31] || (quantum_units == '0)) begin
          state_next = ST_NUDGE;
        end else begin
          state_next = ST_MOD;
        end
      end
      ST_MOD:    if (cnt == ModLast) state_next = ST_NUDGE;
      ST_NUDGE:  state_next = ST_FINISH;
      ST_FINISH: if (fin_load) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs: stall and shared-unit operands
  always_comb begin
    item_stall = (state != ST_IDLE);
    alu_a      = acc;
    alu_b      = '0;
    alu_sub    = 1'b0;
    unique case (state)
      ST_MUL:    alu_b = mplier[0] ? mcand : '0;
      ST_DIV: begin
        alu_a   = {1'b0, rem, quo[NsecW-1]};
        alu_b   = {2'b0, nanoseconds_per_unit};
        alu_sub = 1'b1;
      end
      ST_ADDQ:   alu_b = {2'b0, quo};
      ST_ADDO:   alu_b = timestamp_offset;
      ST_SUBD: begin
        alu_b   = next_timestamp;
        alu_sub = 1'b1;
      end
      ST_MOD: begin
        alu_a   = {15'b0, rem[QuantW-1:0], mcand[TsW-1]};
        alu_b   = {16'b0, quantum_units};
        alu_sub = 1'b1;
      end
      ST_NUDGE: begin
        alu_a = back ? next_timestamp : acc;
        alu_b = {31'b0, nudge};
      end
      ST_FINISH: begin
        alu_a = ts_sel;
        alu_b = {16'b0, quantum_units};
      end
      default: begin
        alu_a = acc;
      end
    endcase
  end

  // RTCP interval counting
  assign rtcp_cnt_inc = rtcp_counter + IntvW'(1);
  assign rtcp_hit     = (rtcp_interval != '0) && (rtcp_cnt_inc >= rtcp_interval);

  // Result fields
  always_comb begin
    result_next = '0;
    if (item_q.action != ACT_SEND) begin
      result_next.status = STS_OTHER;
    end else if (!endpoint_ready) begin
      result_next.status = STS_REJECT;
    end else begin
      result_next.status        = STS_EMIT;
      result_next.marker_out    = item_q.marker_in || (item_q.mark_on_seed && reseed);
      result_next.type_out      = item_q.media_type;
      result_next.sequence_out  = next_sequence;
      result_next.timestamp_out = ts_sel;
      result_next.source_out    = source_id;
      if (item_q.rtcp_now || rtcp_hit) begin
        result_next.rtcp_request   = 1'b1;
        result_next.rtcp_timestamp = ts_sel;
      end
    end
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the transaction and run the shared unit
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        item_q <= item;
      end
      ST_DECIDE: begin
        reseed <= reseed_go;
        back   <= 1'b0;
        cnt    <= '0;
        acc    <= '0;
        mcand  <= item_q.now_sec;
        mplier <= units_per_second;
      end
      ST_MUL: begin
        acc    <= alu_sum[TsW-1:0];
        mcand  <= {mcand[TsW-2:0], 1'b0};
        mplier <= {1'b0, mplier[UpsW-1:1]};
        cnt    <= cnt + CntW'(1);
        if (cnt == MulLast) begin
          cnt <= '0;
          rem <= '0;
          quo <= (nanoseconds_per_unit == '0) ? '0 : item_q.now_nsec;
        end
      end
      ST_DIV: begin
        rem <= alu_sum[32] ? alu_sum[NpuW-1:0] : {rem[NpuW-2:0], quo[NsecW-1]};
        quo <= {quo[NsecW-2:0], alu_sum[32]};
        cnt <= cnt + CntW'(1);
      end
      ST_ADDQ, ST_ADDO, ST_NUDGE: begin
        acc <= alu_sum[TsW-1:0];
      end
      ST_SUBD: begin
        mcand <= alu_sum[TsW-1:0];
        back  <= (alu_sum[31:0] == '0) || alu_sum[31];
        rem   <= '0;
        cnt   <= '0;
      end
      ST_MOD: begin
        rem   <= alu_sum[32] ? {14'b0, alu_sum[QuantW-1:0]}
                             : {14'b0, rem[QuantW-2:0], mcand[TsW-1]};
        mcand <= {mcand[TsW-2:0], 1'b0};
        cnt   <= cnt + CntW'(1);
      end
      ST_FINISH: begin
        acc <= acc;
      end
      default: begin
        acc <= acc;
      end
    endcase
  end

  // Configuration writes, except the sequence load
  always_ff @(posedge clk) begin
    if (rst) begin
      endpoint_ready       <= 1'b0;
      units_per_second     <= UpsReset;
      nanoseconds_per_unit <= NpuReset;
      quantum_units        <= QuantumReset;
      timestamp_offset     <= '0;
      source_id            <= '0;
      rtcp_interval        <= '0;
      initial_sequence     <= '0;
    end else if (cfg_write) begin
      unique case (paddr[AddrW-1:2])
        REG_READY:   endpoint_ready       <= pwdata[0];
        REG_UPS:     units_per_second     <= pwdata[UpsW-1:0];
        REG_NPU:     nanoseconds_per_unit <= pwdata[NpuW-1:0];
        REG_QUANTUM: quantum_units        <= pwdata[QuantW-1:0];
        REG_OFFSET:  timestamp_offset     <= pwdata;
        REG_SOURCE:  source_id            <= pwdata;
        REG_RTCP:    rtcp_interval        <= pwdata[IntvW-1:0];
        REG_INITSEQ: initial_sequence     <= pwdata[SeqW-1:0];
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (paddr[AddrW-1:2])
      REG_READY:   prdata = {31'b0, endpoint_ready};
      REG_UPS:     prdata = {12'b0, units_per_second};
      REG_NPU:     prdata = {2'b0, nanoseconds_per_unit};
      REG_QUANTUM: prdata = {16'b0, quantum_units};
      REG_OFFSET:  prdata = timestamp_offset;
      REG_SOURCE:  prdata = source_id;
      REG_RTCP:    prdata = {16'b0, rtcp_interval};
      REG_INITSEQ: prdata = {16'b0, initial_sequence};
    endcase
  end

  // Load the sequence on an initial-sequence write; else advance protocol state when the result is loaded
  always_ff @(posedge clk) begin
    if (rst) begin
      started         <= 1'b0;
      restart_pending <= 1'b0;
      next_sequence   <= '0;
      next_timestamp  <= '0;
      rtcp_counter    <= '0;
      packet_count    <= '0;
      byte_count      <= '0;
    end else if (cfg_write && (paddr[AddrW-1:2] == REG_INITSEQ)) begin
      next_sequence <= pwdata[SeqW-1:0];
    end else if (fin_load) begin
      if (item_q.action == ACT_SKIP) begin
        if (started && !restart_pending) next_timestamp <= alu_sum[TsW-1:0];
      end else if (item_q.action == ACT_RESTART) begin
        restart_pending <= 1'b1;
      end else if (emit) begin
        started         <= 1'b1;
        restart_pending <= 1'b0;
        next_sequence   <= next_sequence + SeqW'(1);
        next_timestamp  <= alu_sum[TsW-1:0];
        packet_count    <= packet_count + 32'd1;
        byte_count      <= byte_count + {48'b0, item_q.data_len};
        if (rtcp_interval != '0) begin
          rtcp_counter <= rtcp_hit ? '0 : rtcp_cnt_inc;
        end
      end
    end
  end

  // Output register: hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fin_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      result <= result_next;
    end
  end

`ifndef SYNTH
  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == ST_FINISH))
    else $error("result raised outside the finish step");

  a_emit_advances_seq: assert property (@(posedge clk) disable iff (rst)
    (fin_load && emit && !cfg_write) |=> (next_sequence == $past(next_sequence) + SeqW'(1)))
    else $error("emitted header did not advance the sequence");

  a_div_remainder: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (rem < nanoseconds_per_unit))
    else $error("divide remainder out of range");

  a_mod_remainder: assert property (@(posedge clk) disable iff (rst)
    (state == ST_NUDGE && !back && (quantum_units != '0)) |->
      (rem < {14'b0, quantum_units}))
    else $error("modulo remainder out of range");

  a_mul_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL) |-> (cnt <= MulLast))
    else $error("multiply step count overran");
`endif

endmodule

`default_nettype wire
